// ----- rtl/core/wsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Work-stealing deque package
// Shared constants, beat types and ring position helpers for the deque.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int DEPTH       = 16;
    localparam int HANDLE_BITS = 32;

    // Ring slot index, position counter (modulo 2*DEPTH) and occupancy widths.
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = $clog2(2 * DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_TAKE  = 2'd1,
        OP_STEAL = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]             operation;
        logic [HANDLE_BITS-1:0] task_handle;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]             status;
        logic [HANDLE_BITS-1:0] handle_out;
        logic [OCC_W-1:0]       occupancy;
    } t_out_beat;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [SLOT_W-1:0] t_slot;

    function automatic t_pos pos_next(input t_pos p);
        pos_next = (p == POS_W'(2 * DEPTH - 1)) ? '0 : p + POS_W'(1);
    endfunction

    function automatic t_pos pos_prev(input t_pos p);
        pos_prev = (p == '0) ? POS_W'(2 * DEPTH - 1) : p - POS_W'(1);
    endfunction

    function automatic t_slot pos_slot(input t_pos p);
        logic [POS_W-1:0] s;
        s = (p >= POS_W'(DEPTH)) ? p - POS_W'(DEPTH) : p;
        pos_slot = s[SLOT_W-1:0];
    endfunction

    // Entries held between top and bottom, counted modulo 2*DEPTH.
    function automatic logic [OCC_W-1:0] held_count(input t_pos top, input t_pos bot);
        logic [POS_W:0] diff;
        diff = (bot >= top) ? {1'b0, bot} - {1'b0, top}
                            : {1'b0, bot} + (POS_W + 1)'(2 * DEPTH) - {1'b0, top};
        held_count = diff[OCC_W-1:0];
    endfunction

endpackage

// ----- rtl/core/wsd_slot_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque slot memory
// Simple dual-port synchronous RAM holding the task handles, with a registered read.
// ----------------------------------------------------------------------------
module wsd_slot_ram
    import wsd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_we,
    input  t_slot                  i_waddr,
    input  logic [HANDLE_BITS-1:0] i_wdata,
    input  logic                   i_re,
    input  t_slot                  i_raddr,
    output logic [HANDLE_BITS-1:0] o_rdata
);

    logic [HANDLE_BITS-1:0] r_mem [DEPTH];
    logic [HANDLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/work_stealing_deque.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Work-stealing deque
// A result beat passes through the pending stage and then the output
// register after its input beat is accepted. Every operation code takes
// the pending stage: an accepted beat waits there while the slot RAM read
// completes, and the input stalls until it has left, so a new operation
// is not taken before the last one has moved on.
// Reset clears the top and bottom positions, so the deque starts empty; the
// slot RAM itself is not cleared and needs no clearing pass. The input stalls
// while reset is held.
// ----------------------------------------------------------------------------
module work_stealing_deque
    import wsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    // Ring positions. Both count modulo 2*DEPTH, so a full ring and an empty
    // ring are told apart without a separate flag.
    t_pos r_top, n_top;
    t_pos r_bot, n_bot;

    // Pending stage: the operation has updated the positions and, for a take
    // or steal, launched its RAM read; the result is formed in the next cycle.
    logic             r_pend;
    logic [1:0]       r_pend_status, n_pend_status;
    logic             r_pend_rd, n_pend_rd;
    logic [OCC_W-1:0] r_pend_occ, n_pend_occ;

    // Output register, which holds a finished beat while the consumer stalls.
    logic      r_out_valid;
    t_out_beat r_out_beat;

    logic                   accept;
    logic [OCC_W-1:0]       held;
    logic                   ram_we;
    logic                   ram_re;
    t_slot                  ram_waddr;
    t_slot                  ram_raddr;
    logic [HANDLE_BITS-1:0] ram_rdata;

    // A new beat is taken only out of reset, when nothing is in flight and the
    // output register is free or is being emptied at this same edge.
    assign o_in_stall = !i_rst_n || r_pend || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign held       = held_count(r_top, r_bot);

    // Decode the operation against the current occupancy.
    always_comb begin
        n_top         = r_top;
        n_bot         = r_bot;
        n_pend_status = ST_EMPTY;
        n_pend_rd     = 1'b0;
        n_pend_occ    = held;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = pos_slot(r_bot);
        ram_raddr     = pos_slot(r_top);
        case (t_op'(i_in_beat.operation))
            OP_PUSH: begin
                if (held == OCC_W'(DEPTH)) begin
                    n_pend_status = ST_FULL;
                end else begin
                    ram_we        = accept;
                    n_bot         = pos_next(r_bot);
                    n_pend_status = ST_OK;
                    n_pend_occ    = held + OCC_W'(1);
                end
            end
            OP_TAKE: begin
                if (held != '0) begin
                    n_bot         = pos_prev(r_bot);
                    ram_raddr     = pos_slot(pos_prev(r_bot));
                    ram_re        = accept;
                    n_pend_rd     = 1'b1;
                    n_pend_status = ST_OK;
                    n_pend_occ    = held - OCC_W'(1);
                end
            end
            OP_STEAL: begin
                if (held != '0) begin
                    n_top         = pos_next(r_top);
                    ram_re        = accept;
                    n_pend_rd     = 1'b1;
                    n_pend_status = ST_OK;
                    n_pend_occ    = held - OCC_W'(1);
                end
            end
            default: begin
                // The unused code changes nothing and reports empty.
                n_pend_status = ST_EMPTY;
            end
        endcase
    end

    wsd_slot_ram u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_beat.task_handle),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top  <= '0;
            r_bot  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= accept;
            if (accept) begin
                r_top <= n_top;
                r_bot <= n_bot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_status <= n_pend_status;
            r_pend_rd     <= n_pend_rd;
            r_pend_occ    <= n_pend_occ;
        end
    end

    // The output register is always free when a pending result lands, since
    // acceptance waited for it to drain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_out_beat.status     <= r_pend_status;
            r_out_beat.handle_out <= r_pend_rd ? ram_rdata : '0;
            r_out_beat.occupancy  <= r_pend_occ;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule
